// ----- rtl/rpr_pkg.sv -----
// Shared types and constants for the rational polyphase resampler.
`timescale 1ns / 1ps
package rpr_pkg;

   localparam int CMD_W       = 2;
   localparam int VALUE_W     = 16;
   localparam int START_W     = 8;
   localparam int TCOUNT_W    = 7;
   localparam int RATE_W      = 7;
   localparam int WIN_W       = 12;
   localparam int CNT_W       = 32;
   localparam int TICK_W      = CNT_W + RATE_W;
   localparam int IDX_W       = CNT_W + 3;
   localparam int ACC_W       = 40;
   localparam int OUT_LIMIT   = 64;
   localparam int RATE_MAX    = 64;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_DATA_W  = 48;
   localparam int ROUND_SHIFT = 15;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_FLUSH  = 2'd1,
      CMD_COEFF  = 2'd2,
      CMD_PHASE  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUT_PER_UNIT = 2'd0,
      CSR_IN_PER_UNIT  = 2'd1,
      CSR_WINDOW       = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic issue;
      logic in_range;
      logic clear;
   } tap_ctrl_type;

   typedef struct packed {
      logic pending;
   } dot_status_type;

endpackage

// ----- rtl/rpr_dot.sv -----
// Coefficient and history stores with the shared multiply-accumulate and Q15 rounding.
`timescale 1ns / 1ps
module rpr_dot #(
   parameter int CAW = 12,
   parameter int HW  = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               coeff_we,
   input  logic [CAW-1:0]                     coeff_waddr,
   input  logic signed [rpr_pkg::VALUE_W-1:0] coeff_wdata,
   input  logic                               hist_we,
   input  logic [HW-1:0]                      hist_waddr,
   input  logic signed [rpr_pkg::VALUE_W-1:0] hist_wdata,
   input  rpr_pkg::tap_ctrl_type              tap_ctrl,
   input  logic [CAW-1:0]                     coeff_raddr,
   input  logic [HW-1:0]                      hist_raddr,
   output rpr_pkg::dot_status_type            status,
   output logic signed [rpr_pkg::VALUE_W-1:0] result
);
   import rpr_pkg::*;

   localparam int CDEPTH = 1 << CAW;
   localparam int HDEPTH = 1 << HW;

   logic signed [VALUE_W-1:0] coeff_mem [CDEPTH];
   logic signed [VALUE_W-1:0] hist_mem  [HDEPTH];
   logic signed [VALUE_W-1:0] c_rd_ff;
   logic signed [VALUE_W-1:0] x_rd_ff;
   logic                      use_ff;
   logic                      pend_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W:0]     biased;
   logic signed [ACC_W:0]     shifted;

   always_ff @(posedge clock) begin
      if (coeff_we) begin
         coeff_mem[coeff_waddr] <= coeff_wdata;
      end
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      c_rd_ff <= coeff_mem[coeff_raddr];
      x_rd_ff <= hist_mem[hist_raddr];
   end

   always_comb begin
      acc_in = acc_ff + ACC_W'(c_rd_ff * x_rd_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_ff  <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         use_ff  <= tap_ctrl.issue & tap_ctrl.in_range;
         pend_ff <= tap_ctrl.issue;
      end
      if (tap_ctrl.clear) begin
         acc_ff <= '0;
      end else if (use_ff) begin
         acc_ff <= acc_in;
      end
   end

   // floor((acc + 0.5 LSB) / 2^15), then clip to the sample range
   always_comb begin
      biased  = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(1 << (ROUND_SHIFT - 1));
      shifted = biased >>> ROUND_SHIFT;
      if (shifted > (ACC_W+1)'((1 << (VALUE_W - 1)) - 1)) begin
         result = VALUE_W'((1 << (VALUE_W - 1)) - 1);
      end else if (shifted < -(ACC_W+1)'(1 << (VALUE_W - 1))) begin
         result = VALUE_W'(1 << (VALUE_W - 1));
      end else begin
         result = shifted[VALUE_W-1:0];
      end
   end

   assign status.pending = pend_ff;

endmodule

// ----- rtl/rational_polyphase_resampler.sv -----
// Top level of the rational polyphase resampler: command decode, sequencer and output stage.
// A load item is written in the idle state. A sample or flush item sends every output it causes
// through the single multiply-accumulate unit (up to 64 outputs per item). A write to either
// rate register rebuilds the phase and unit position with a bit-serial divider. HIST_DEPTH
// must be a power of two.
`timescale 1ns / 1ps
module rational_polyphase_resampler #(
   parameter int MAX_PHASES = 64,
   parameter int MAX_TAPS   = 64,
   parameter int HIST_DEPTH = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // phase[5:0], tap[11:6], value[27:12], start_offset[35:28], tap_count[42:36], zero pad
   input  logic [rpr_pkg::REQ_DATA_W-1:0]        req_tdata,
   // cmd[1:0]
   input  logic [rpr_pkg::CMD_W-1:0]             req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // sample_out[15:0]
   output logic [rpr_pkg::VALUE_W-1:0]           rsp_tdata,
   output logic                                  rsp_tlast,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rpr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rpr_pkg::WIN_W-1:0]             csr_data
);
   import rpr_pkg::*;

   localparam int PHW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
   localparam int TCW = $clog2(MAX_TAPS + 1);
   localparam int CAW = (MAX_PHASES * MAX_TAPS > 1) ? $clog2(MAX_PHASES * MAX_TAPS) : 1;
   localparam int HW  = $clog2(HIST_DEPTH);
   localparam int PHASE_LIM = (MAX_PHASES < RATE_MAX) ? MAX_PHASES : RATE_MAX;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LIM, ST_MULO, ST_CMP, ST_DESC, ST_MAC, ST_ROUND, ST_PUSH, ST_DIV, ST_SCALE
   } state_type;

   state_type                   state_ff;
   logic [RATE_W-1:0]           opu_ff;
   logic [RATE_W-1:0]           ipu_ff;
   logic [WIN_W-1:0]            win_ff;
   logic [CNT_W-1:0]            ins_ff;
   logic [CNT_W-1:0]            od_ff;
   logic [PHW-1:0]              phase_now_ff;
   logic [CNT_W-1:0]            base_ff;
   logic [TICK_W-1:0]           lim_ff;
   logic [TICK_W-1:0]           prod_ff;
   logic                        flush_ff;
   logic                        have_ff;
   logic                        more_ff;
   logic [RATE_W-1:0]           n_ff;
   logic [VALUE_W-1:0]          res_ff;
   logic signed [IDX_W-1:0]     i_ff;
   logic signed [IDX_W-1:0]     lo_ff;
   logic [TCW-1:0]              j_ff;
   logic [TCW-1:0]              taps_ff;
   logic [CNT_W-1:0]            dq_ff;
   logic [RATE_W-1:0]           rem_ff;
   logic [5:0]                  div_cnt_ff;
   logic                        rsp_tvalid_ff;
   logic [VALUE_W-1:0]          rsp_data_ff;
   logic                        rsp_last_ff;

   logic [START_W-1:0]          start_mem [MAX_PHASES];
   logic [TCW-1:0]              taps_mem  [MAX_PHASES];
   logic [START_W-1:0]          start_rd_ff;
   logic [TCW-1:0]              taps_rd_ff;

   logic                        req_fire;
   logic                        csr_fire;
   cmd_type                     cmd;
   logic [8:0]                  ph_ext;
   logic [8:0]                  tp_ext;
   logic [8:0]                  tc_ext;
   logic [PHW-1:0]              ld_ph;
   logic [TCW-1:0]              ld_tc;
   logic                        ph_ok;
   logic                        tp_ok;
   logic [RATE_W-1:0]           rate_in;
   logic [CNT_W-1:0]            mul_a;
   logic [RATE_W-1:0]           mul_b;
   logic [TICK_W-1:0]           mul_p;
   logic [TICK_W:0]             need_ticks;
   logic                        more_in;
   logic [RATE_W:0]             trial;
   logic [RATE_W-1:0]           phase_inc;
   logic signed [IDX_W-1:0]     hi;
   logic                        coeff_we;
   logic [CAW-1:0]              coeff_waddr;
   logic                        hist_we;
   logic                        push_ok;
   tap_ctrl_type                tap_ctrl;
   dot_status_type              dot_status;
   logic signed [VALUE_W-1:0]   dot_result;
   logic [CAW-1:0]              coeff_raddr;

   assign req_fire = req_tvalid && req_tready;
   assign csr_fire = csr_valid && csr_ready;
   // a register write takes the idle slot ahead of an item
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign cmd = cmd_type'(req_tuser);

   assign ph_ext = {3'b000, req_tdata[5:0]};
   assign tp_ext = {3'b000, req_tdata[11:6]};
   assign tc_ext = {2'b00, req_tdata[42:36]};
   assign ph_ok  = ph_ext < 9'(MAX_PHASES);
   assign tp_ok  = tp_ext < 9'(MAX_TAPS);
   assign ld_ph  = ph_ext[PHW-1:0];
   assign ld_tc  = (tc_ext > 9'(MAX_TAPS)) ? TCW'(MAX_TAPS) : tc_ext[TCW-1:0];

   assign coeff_we    = req_fire && cmd == CMD_COEFF && ph_ok && tp_ok;
   assign coeff_waddr = CAW'(32'(ph_ext) * MAX_TAPS + 32'(tp_ext));
   assign hist_we     = req_fire && cmd == CMD_SAMPLE && ins_ff != '1;

   always_comb begin
      rate_in = csr_data[RATE_W-1:0];
      if (rate_in == '0) begin
         rate_in = RATE_W'(1);
      end else if (rate_in > RATE_W'(RATE_MAX)) begin
         rate_in = RATE_W'(RATE_MAX);
      end
   end

   // shared 32x7 multiplier: limit ticks, output ticks, unit base after a rate change
   always_comb begin
      mul_a = od_ff;
      mul_b = ipu_ff;
      case (state_ff)
         ST_LIM: begin
            mul_a = ins_ff;
            mul_b = opu_ff;
         end
         ST_SCALE: begin
            mul_a = dq_ff;
            mul_b = ipu_ff;
         end
         default: begin
         end
      endcase
      mul_p = TICK_W'(mul_a) * TICK_W'(mul_b);
   end

   assign need_ticks = (TICK_W+1)'(prod_ff) + (TICK_W+1)'(flush_ff ? '0 : win_ff);
   assign more_in    = (n_ff < RATE_W'(OUT_LIMIT)) && (need_ticks < (TICK_W+1)'(lim_ff));
   assign trial      = {rem_ff, dq_ff[CNT_W-1]};
   assign phase_inc  = RATE_W'(phase_now_ff) + RATE_W'(1);
   assign hi         = $signed(IDX_W'(ins_ff));
   assign push_ok    = !rsp_tvalid_ff || rsp_tready;

   assign coeff_raddr       = CAW'(32'(phase_now_ff) * MAX_TAPS + 32'(j_ff));
   assign tap_ctrl.issue    = (state_ff == ST_MAC) && (j_ff < taps_ff);
   assign tap_ctrl.in_range = (i_ff >= lo_ff) && (i_ff < hi);
   assign tap_ctrl.clear    = (state_ff == ST_DESC);

   always_ff @(posedge clock) begin
      if (req_fire && cmd == CMD_PHASE && ph_ok) begin
         start_mem[ld_ph] <= req_tdata[35:28];
         taps_mem[ld_ph]  <= ld_tc;
      end
      start_rd_ff <= start_mem[phase_now_ff];
      taps_rd_ff  <= taps_mem[phase_now_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         opu_ff        <= RATE_W'(1);
         ipu_ff        <= RATE_W'(1);
         win_ff        <= '0;
         ins_ff        <= '0;
         od_ff         <= '0;
         phase_now_ff  <= '0;
         base_ff       <= '0;
         flush_ff      <= 1'b0;
         have_ff       <= 1'b0;
         more_ff       <= 1'b0;
         n_ff          <= '0;
         rsp_tvalid_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
         div_cnt_ff    <= '0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && state_ff != ST_PUSH) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (csr_fire) begin
                  unique case (csr_idx_type'(csr_index))
                     CSR_OUT_PER_UNIT: begin
                        opu_ff     <= (rate_in > RATE_W'(PHASE_LIM)) ?
                                      RATE_W'(PHASE_LIM) : rate_in;
                        dq_ff      <= od_ff;
                        rem_ff     <= '0;
                        div_cnt_ff <= '0;
                        state_ff   <= ST_DIV;
                     end
                     CSR_IN_PER_UNIT: begin
                        ipu_ff     <= rate_in;
                        dq_ff      <= od_ff;
                        rem_ff     <= '0;
                        div_cnt_ff <= '0;
                        state_ff   <= ST_DIV;
                     end
                     CSR_WINDOW: begin
                        win_ff <= csr_data;
                     end
                     CSR_UNUSED: begin
                     end
                  endcase
               end else if (req_fire) begin
                  n_ff    <= '0;
                  have_ff <= 1'b0;
                  unique case (cmd)
                     CMD_SAMPLE: begin
                        if (ins_ff != '1) begin
                           ins_ff   <= ins_ff + CNT_W'(1);
                           flush_ff <= 1'b0;
                           state_ff <= ST_LIM;
                        end
                     end
                     CMD_FLUSH: begin
                        flush_ff <= 1'b1;
                        state_ff <= ST_LIM;
                     end
                     CMD_COEFF, CMD_PHASE: begin
                     end
                  endcase
               end
            end
            ST_LIM: begin
               lim_ff   <= mul_p;
               state_ff <= ST_MULO;
            end
            ST_MULO: begin
               prod_ff  <= mul_p;
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               more_ff <= more_in;
               if (have_ff) begin
                  state_ff <= ST_PUSH;
               end else if (more_in) begin
                  state_ff <= ST_DESC;
               end else begin
                  state_ff <= ST_IDLE;
                  if (flush_ff) begin
                     ins_ff       <= '0;
                     od_ff        <= '0;
                     phase_now_ff <= '0;
                     base_ff      <= '0;
                  end
               end
            end
            ST_DESC: begin
               i_ff     <= $signed(IDX_W'($signed(start_rd_ff))) + $signed(IDX_W'(base_ff));
               lo_ff    <= (ins_ff > CNT_W'(HIST_DEPTH)) ?
                           $signed(IDX_W'(ins_ff - CNT_W'(HIST_DEPTH))) : '0;
               taps_ff  <= taps_rd_ff;
               j_ff     <= '0;
               state_ff <= ST_MAC;
            end
            ST_MAC: begin
               if (j_ff < taps_ff) begin
                  i_ff <= i_ff + IDX_W'(1);
                  j_ff <= j_ff + TCW'(1);
               end else if (!dot_status.pending) begin
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               res_ff  <= dot_result;
               od_ff   <= od_ff + CNT_W'(1);
               n_ff    <= n_ff + RATE_W'(1);
               have_ff <= 1'b1;
               if (phase_inc == opu_ff) begin
                  phase_now_ff <= '0;
                  base_ff      <= base_ff + CNT_W'(ipu_ff);
               end else begin
                  phase_now_ff <= phase_inc[PHW-1:0];
               end
               state_ff <= ST_MULO;
            end
            ST_PUSH: begin
               if (push_ok) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_data_ff   <= res_ff;
                  rsp_last_ff   <= flush_ff && !more_ff;
                  have_ff       <= 1'b0;
                  if (more_ff) begin
                     state_ff <= ST_DESC;
                  end else begin
                     state_ff <= ST_IDLE;
                     if (flush_ff) begin
                        ins_ff       <= '0;
                        od_ff        <= '0;
                        phase_now_ff <= '0;
                        base_ff      <= '0;
                     end
                  end
               end
            end
            ST_DIV: begin
               if (trial >= (RATE_W+1)'(opu_ff)) begin
                  rem_ff <= RATE_W'(trial - (RATE_W+1)'(opu_ff));
                  dq_ff  <= {dq_ff[CNT_W-2:0], 1'b1};
               end else begin
                  rem_ff <= trial[RATE_W-1:0];
                  dq_ff  <= {dq_ff[CNT_W-2:0], 1'b0};
               end
               div_cnt_ff <= div_cnt_ff + 6'd1;
               if (div_cnt_ff == 6'(CNT_W - 1)) begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               base_ff      <= mul_p[CNT_W-1:0];
               phase_now_ff <= rem_ff[PHW-1:0];
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   rpr_dot #(
      .CAW (CAW),
      .HW  (HW)
   ) u_dot (
      .clock       (clock),
      .reset       (reset),
      .coeff_we    (coeff_we),
      .coeff_waddr (coeff_waddr),
      .coeff_wdata (req_tdata[27:12]),
      .hist_we     (hist_we),
      .hist_waddr  (ins_ff[HW-1:0]),
      .hist_wdata  (req_tdata[27:12]),
      .tap_ctrl    (tap_ctrl),
      .coeff_raddr (coeff_raddr),
      .hist_raddr  (i_ff[HW-1:0]),
      .status      (dot_status),
      .result      (dot_result)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_phase_below_rate: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIV && state_ff != ST_SCALE) |-> RATE_W'(phase_now_ff) < opu_ff)
      else $error("phase index beyond out_per_unit");

   a_output_budget: assert property (@(posedge clock) disable iff (reset)
      n_ff <= RATE_W'(OUT_LIMIT))
      else $error("too many outputs for one item");

   a_flush_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH && push_ok && flush_ff && !more_ff) |=>
         (od_ff == '0 && ins_ff == '0 && rsp_tlast))
      else $error("flush end did not restart the stream");

endmodule
